[hw/rtl/ams_pkg.sv]
// ----------------------------------------------------------------------------
// ams_pkg
// Shared types, constants and helpers of the audio module command serializer.
// ----------------------------------------------------------------------------
package ams_pkg;

  localparam int unsigned TRACK_COUNT = 512;
  localparam int unsigned FRAME_BITS  = 16;
  localparam int unsigned TRACK_W     = $clog2(TRACK_COUNT + 1);
  localparam int unsigned BITS_W      = $clog2(FRAME_BITS + 1);
  localparam int unsigned WORD_W      = 16;
  localparam int unsigned VOL_W       = 4;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 16;

  // Register reset values
  localparam logic [WORD_W-1:0] RST_PLAY_PAUSE  = 16'hFFFE;
  localparam logic [WORD_W-1:0] RST_STOP        = 16'hFFFF;
  localparam logic [WORD_W-1:0] RST_VOLUME_BASE = 16'hFFF0;
  localparam logic [VOL_W-1:0]  RST_MIN_VOLUME  = 4'd1;
  localparam logic [VOL_W-1:0]  RST_MAX_VOLUME  = 4'd7;
  localparam logic [15:0]       RST_HOLD_TICKS  = 16'd500;
  localparam logic [15:0]       RST_LOW_TICKS   = 16'd20;
  localparam logic [15:0]       RST_HALF_TICKS  = 16'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PLAY_PAUSE_CODE  = 3'd0,
    CFG_STOP_CODE        = 3'd1,
    CFG_VOLUME_BASE_CODE = 3'd2,
    CFG_MIN_VOLUME       = 3'd3,
    CFG_MAX_VOLUME       = 3'd4,
    CFG_START_HOLD_TICKS = 3'd5,
    CFG_START_LOW_TICKS  = 3'd6,
    CFG_HALF_BIT_TICKS   = 3'd7
  } cfg_idx_e;

  typedef enum logic [3:0] {
    OP_TICK       = 4'd0,
    OP_RESET      = 4'd1,
    OP_PLAY_PAUSE = 4'd2,
    OP_PLAY_SONG  = 4'd3,
    OP_STOP       = 4'd4,
    OP_NEXT       = 4'd5,
    OP_PREV       = 4'd6,
    OP_SET_VOL    = 4'd7,
    OP_INC_VOL    = 4'd8,
    OP_DEC_VOL    = 4'd9
  } op_e;

  typedef struct packed {
    logic [WORD_W-1:0] play_pause_code;
    logic [WORD_W-1:0] stop_code;
    logic [WORD_W-1:0] volume_base_code;
    logic [VOL_W-1:0]  min_volume;
    logic [VOL_W-1:0]  max_volume;
    logic [15:0]       start_hold_ticks;
    logic [15:0]       start_low_ticks;
    logic [15:0]       half_bit_ticks;
  } cfg_t;

  typedef struct packed {
    logic [3:0]        op;
    logic [15:0]       song_index;
    logic signed [7:0] level;
    logic              busy;
  } in_item_t;

  typedef struct packed {
    logic               clock_line;
    logic               data_line;
    logic               reset_pulse;
    logic               accepted;
    logic [WORD_W-1:0]  frame_word;
    logic               sending;
    logic [VOL_W-1:0]   volume_now;
    logic [TRACK_W-1:0] track_now;
  } out_item_t;

  // Control from command logic to the frame engine, strobes qualified by fire
  typedef struct packed {
    logic              step;
    logic              start;
    logic              abort;
    logic [WORD_W-1:0] word;
  } frame_req_t;

  // Line and frame status after the current request
  typedef struct packed {
    logic              clock_line;
    logic              data_line;
    logic              sending;
    logic [WORD_W-1:0] frame_word;
  } frame_stat_t;

  // A duration of zero ticks behaves as one tick
  function automatic logic [15:0] dur(input logic [15:0] t);
    return (t == 16'd0) ? 16'd1 : t;
  endfunction

endpackage

[hw/rtl/ams_cfg.sv]
// ----------------------------------------------------------------------------
// ams_cfg
// Configuration register file, write-only.
// ----------------------------------------------------------------------------
module ams_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [ams_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [ams_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  output ams_pkg::cfg_t                  cfg_o
);

  ams_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (ams_pkg::cfg_idx_e'(cfg_idx_i))
        ams_pkg::CFG_PLAY_PAUSE_CODE:  cfg_d.play_pause_code  = cfg_wdata_i;
        ams_pkg::CFG_STOP_CODE:        cfg_d.stop_code        = cfg_wdata_i;
        ams_pkg::CFG_VOLUME_BASE_CODE: cfg_d.volume_base_code = cfg_wdata_i;
        ams_pkg::CFG_MIN_VOLUME:       cfg_d.min_volume = cfg_wdata_i[ams_pkg::VOL_W-1:0];
        ams_pkg::CFG_MAX_VOLUME:       cfg_d.max_volume = cfg_wdata_i[ams_pkg::VOL_W-1:0];
        ams_pkg::CFG_START_HOLD_TICKS: cfg_d.start_hold_ticks = cfg_wdata_i;
        ams_pkg::CFG_START_LOW_TICKS:  cfg_d.start_low_ticks  = cfg_wdata_i;
        ams_pkg::CFG_HALF_BIT_TICKS:   cfg_d.half_bit_ticks   = cfg_wdata_i;
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.play_pause_code  <= ams_pkg::RST_PLAY_PAUSE;
      cfg_q.stop_code        <= ams_pkg::RST_STOP;
      cfg_q.volume_base_code <= ams_pkg::RST_VOLUME_BASE;
      cfg_q.min_volume       <= ams_pkg::RST_MIN_VOLUME;
      cfg_q.max_volume       <= ams_pkg::RST_MAX_VOLUME;
      cfg_q.start_hold_ticks <= ams_pkg::RST_HOLD_TICKS;
      cfg_q.start_low_ticks  <= ams_pkg::RST_LOW_TICKS;
      cfg_q.half_bit_ticks   <= ams_pkg::RST_HALF_TICKS;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

[hw/rtl/ams_ctrl.sv]
// ----------------------------------------------------------------------------
// ams_ctrl
// Command decode: track and volume state, frame start requests.
// ----------------------------------------------------------------------------
module ams_ctrl (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         fire_i,
  input  ams_pkg::in_item_t            item_i,
  input  ams_pkg::cfg_t                cfg_i,
  input  logic                         framing_i,
  output ams_pkg::frame_req_t          req_o,
  output logic                         accepted_o,
  output logic                         reset_pulse_o,
  output logic [ams_pkg::TRACK_W-1:0]  track_d_o,
  output logic [ams_pkg::VOL_W-1:0]    volume_d_o
);

  logic [ams_pkg::TRACK_W-1:0] track_q, track_d;
  logic [ams_pkg::VOL_W-1:0]   vol_q, vol_d;

  logic                        start;
  logic [ams_pkg::WORD_W-1:0]  word;
  logic                        play_req, stop_req, vol_req;
  logic [15:0]                 play_idx;
  logic signed [8:0]           vol_arg;
  logic [ams_pkg::VOL_W-1:0]   vol_clamp;

  always_comb begin
    accepted_o    = 1'b1;
    reset_pulse_o = 1'b0;
    start         = 1'b0;
    word          = '0;
    track_d       = track_q;
    vol_d         = vol_q;
    play_req      = 1'b0;
    stop_req      = 1'b0;
    vol_req       = 1'b0;
    play_idx      = '0;
    vol_arg       = '0;
    vol_clamp     = '0;

    case (ams_pkg::op_e'(item_i.op))
      ams_pkg::OP_TICK: ;
      ams_pkg::OP_RESET: begin
        reset_pulse_o = 1'b1;
        track_d       = ams_pkg::TRACK_W'(ams_pkg::TRACK_COUNT);
        vol_d         = cfg_i.max_volume;
        start         = 1'b1;
        word          = cfg_i.play_pause_code;
      end
      ams_pkg::OP_PLAY_PAUSE, ams_pkg::OP_PLAY_SONG, ams_pkg::OP_STOP,
      ams_pkg::OP_NEXT, ams_pkg::OP_PREV, ams_pkg::OP_SET_VOL,
      ams_pkg::OP_INC_VOL, ams_pkg::OP_DEC_VOL: begin
        if (framing_i) begin
          accepted_o = 1'b0;
        end else begin
          case (ams_pkg::op_e'(item_i.op))
            ams_pkg::OP_PLAY_PAUSE: begin
              start = 1'b1;
              word  = item_i.busy ? cfg_i.play_pause_code : '0;
            end
            ams_pkg::OP_PLAY_SONG: begin
              play_req = 1'b1;
              play_idx = item_i.song_index;
            end
            ams_pkg::OP_STOP: stop_req = 1'b1;
            ams_pkg::OP_NEXT: begin
              play_req = 1'b1;
              play_idx = item_i.busy ? (16'(track_q) + 16'd1) : 16'd0;
            end
            ams_pkg::OP_PREV: begin
              if (item_i.busy) begin
                if (track_q == '0) begin
                  stop_req = 1'b1;
                end else begin
                  play_req = 1'b1;
                  play_idx = 16'(track_q) - 16'd1;
                end
              end
            end
            ams_pkg::OP_SET_VOL: begin
              vol_req = 1'b1;
              vol_arg = {item_i.level[7], item_i.level};
            end
            ams_pkg::OP_INC_VOL: begin
              vol_req = 1'b1;
              vol_arg = {5'd0, vol_q} + 9'sd1;
            end
            ams_pkg::OP_DEC_VOL: begin
              vol_req = 1'b1;
              vol_arg = {5'd0, vol_q} - 9'sd1;
            end
            default: ;
          endcase
        end
      end
      default: accepted_o = 1'b0;
    endcase

    // out-of-range track falls back to stop
    if (play_req) begin
      if (play_idx < 16'(ams_pkg::TRACK_COUNT)) begin
        track_d = ams_pkg::TRACK_W'(play_idx);
        start   = 1'b1;
        word    = play_idx;
      end else begin
        stop_req = 1'b1;
      end
    end

    if (stop_req) begin
      track_d = ams_pkg::TRACK_W'(ams_pkg::TRACK_COUNT);
      start   = 1'b1;
      word    = cfg_i.stop_code;
    end

    // min check wins over max check
    if (vol_req) begin
      if (vol_arg < $signed({5'd0, cfg_i.min_volume})) begin
        vol_clamp = cfg_i.min_volume;
      end else if (vol_arg > $signed({5'd0, cfg_i.max_volume})) begin
        vol_clamp = cfg_i.max_volume;
      end else begin
        vol_clamp = vol_arg[ams_pkg::VOL_W-1:0];
      end
      if (vol_clamp != vol_q) begin
        vol_d = vol_clamp;
        start = 1'b1;
        word  = ams_pkg::WORD_W'(vol_clamp) + cfg_i.volume_base_code;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      track_q <= ams_pkg::TRACK_W'(ams_pkg::TRACK_COUNT);
      vol_q   <= ams_pkg::RST_MAX_VOLUME;
    end else if (fire_i) begin
      track_q <= track_d;
      vol_q   <= vol_d;
    end
  end

  assign req_o.step  = fire_i && (ams_pkg::op_e'(item_i.op) == ams_pkg::OP_TICK);
  assign req_o.start = fire_i && start;
  assign req_o.abort = fire_i && reset_pulse_o;
  assign req_o.word  = word;
  assign track_d_o   = track_d;
  assign volume_d_o  = vol_d;

endmodule

[hw/rtl/ams_frame.sv]
// ----------------------------------------------------------------------------
// ams_frame
// Frame engine: start hold, start low, then the bits MSB first; the phase
// timer counts down only on tick requests.
// ----------------------------------------------------------------------------
module ams_frame (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ams_pkg::cfg_t        cfg_i,
  input  ams_pkg::frame_req_t  req_i,
  output logic                 framing_o,
  output ams_pkg::frame_stat_t stat_d_o
);

  typedef enum logic [4:0] {
    PH_IDLE     = 5'b00001,
    PH_HOLD     = 5'b00010,
    PH_START_LOW = 5'b00100,
    PH_BIT_LOW  = 5'b01000,
    PH_BIT_HIGH = 5'b10000
  } phase_e;

  phase_e                          phase_q, phase_d;
  logic [15:0]                     timer_q, timer_d, timer_dec;
  logic [ams_pkg::FRAME_BITS-1:0]  shift_q, shift_d;
  logic [ams_pkg::BITS_W-1:0]      bits_q, bits_d;
  logic                            clock_q, clock_d;
  logic                            data_q, data_d;
  logic [ams_pkg::WORD_W-1:0]      word_q, word_d;

  assign timer_dec = (timer_q == 16'd0) ? 16'd0 : timer_q - 16'd1;

  always_comb begin
    phase_d = phase_q;
    timer_d = timer_q;
    shift_d = shift_q;
    bits_d  = bits_q;
    clock_d = clock_q;
    data_d  = data_q;
    word_d  = word_q;

    if (req_i.start) begin
      if (req_i.abort) begin
        data_d = 1'b0;
      end
      word_d  = req_i.word;
      shift_d = ams_pkg::FRAME_BITS'(req_i.word);
      bits_d  = ams_pkg::BITS_W'(ams_pkg::FRAME_BITS);
      phase_d = PH_HOLD;
      timer_d = ams_pkg::dur(cfg_i.start_hold_ticks);
      clock_d = 1'b1;
    end else if (req_i.step && (phase_q != PH_IDLE)) begin
      timer_d = timer_dec;
      if (timer_dec == 16'd0) begin
        case (phase_q)
          PH_HOLD: begin
            phase_d = PH_START_LOW;
            clock_d = 1'b0;
            timer_d = ams_pkg::dur(cfg_i.start_low_ticks);
          end
          PH_START_LOW, PH_BIT_HIGH: begin
            if ((phase_q == PH_BIT_HIGH) && (bits_q == '0)) begin
              phase_d = PH_IDLE;
              data_d  = 1'b0;
              clock_d = 1'b1;
              timer_d = 16'd0;
            end else begin
              phase_d = PH_BIT_LOW;
              clock_d = 1'b0;
              data_d  = shift_q[ams_pkg::FRAME_BITS-1];
              shift_d = shift_q << 1;
              bits_d  = bits_q - ams_pkg::BITS_W'(1);
              timer_d = ams_pkg::dur(cfg_i.half_bit_ticks);
            end
          end
          PH_BIT_LOW: begin
            phase_d = PH_BIT_HIGH;
            clock_d = 1'b1;
            timer_d = ams_pkg::dur(cfg_i.half_bit_ticks);
          end
          default: begin
            phase_d = PH_IDLE;
            clock_d = 1'b1;
            data_d  = 1'b0;
            timer_d = 16'd0;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      timer_q <= '0;
      shift_q <= '0;
      bits_q  <= '0;
      clock_q <= 1'b1;
      data_q  <= 1'b0;
      word_q  <= '0;
    end else begin
      phase_q <= phase_d;
      timer_q <= timer_d;
      shift_q <= shift_d;
      bits_q  <= bits_d;
      clock_q <= clock_d;
      data_q  <= data_d;
      word_q  <= word_d;
    end
  end

  assign framing_o           = (phase_q != PH_IDLE);
  assign stat_d_o.clock_line = clock_d;
  assign stat_d_o.data_line  = data_d;
  assign stat_d_o.sending    = (phase_d != PH_IDLE);
  assign stat_d_o.frame_word = word_d;

endmodule

[hw/rtl/audio_module_command_serializer.sv]
// ----------------------------------------------------------------------------
// audio_module_command_serializer
// Two-wire command serializer for an audio playback module.
// ----------------------------------------------------------------------------
// One request in, one result out. A request is registered at the input; when
// the output register is free, its command and frame-timing updates are made
// and the result lands there. A new request is taken every cycle while the
// output is not stalled, as the track, volume and frame state update together
// with each result. A stalled output holds its result; the input register
// keeps taking requests until it is itself full behind a stalled output.
// Frame timing on the module lines advances only on tick requests.
module audio_module_command_serializer (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [ams_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [ams_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  ams_pkg::in_item_t              in_item_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output ams_pkg::out_item_t             out_item_o
);

  ams_pkg::cfg_t         cfg;
  ams_pkg::frame_req_t   frame_req;
  ams_pkg::frame_stat_t  frame_stat_d;
  logic                  framing;
  logic                  accepted, reset_pulse;
  logic [ams_pkg::TRACK_W-1:0] track_d;
  logic [ams_pkg::VOL_W-1:0]   volume_d;

  logic                  s1_valid_q;
  ams_pkg::in_item_t     s1_item_q;
  logic                  out_valid_q;
  ams_pkg::out_item_t    out_item_q, out_item_d;
  logic                  out_free, fire, in_take;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign fire       = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;
  assign in_take    = in_valid_i && !in_stall_o;

  ams_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  ams_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .fire_i        (fire),
    .item_i        (s1_item_q),
    .cfg_i         (cfg),
    .framing_i     (framing),
    .req_o         (frame_req),
    .accepted_o    (accepted),
    .reset_pulse_o (reset_pulse),
    .track_d_o     (track_d),
    .volume_d_o    (volume_d)
  );

  ams_frame u_frame (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .req_i     (frame_req),
    .framing_o (framing),
    .stat_d_o  (frame_stat_d)
  );

  always_comb begin
    out_item_d.clock_line  = frame_stat_d.clock_line;
    out_item_d.data_line   = frame_stat_d.data_line;
    out_item_d.reset_pulse = reset_pulse;
    out_item_d.accepted    = accepted;
    out_item_d.frame_word  = frame_stat_d.frame_word;
    out_item_d.sending     = frame_stat_d.sending;
    out_item_d.volume_now  = volume_d;
    out_item_d.track_now   = track_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_take) begin
        s1_valid_q <= 1'b1;
      end else if (fire) begin
        s1_valid_q <= 1'b0;
      end
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_item_q <= in_item_i;
    end
    if (fire) begin
      out_item_q <= out_item_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

[hw/rtl/ams_checker.sv]
// ----------------------------------------------------------------------------
// ams_checker
// Port-level checks on the result channel of the command serializer.
// ----------------------------------------------------------------------------
module ams_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input ams_pkg::out_item_t out_item_o
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("result changed while stalled");

  // a reset request always starts a fresh frame with the track stopped
  a_reset_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.reset_pulse |->
      out_item_o.accepted && out_item_o.sending && out_item_o.clock_line &&
      !out_item_o.data_line &&
      (out_item_o.track_now == ams_pkg::TRACK_W'(ams_pkg::TRACK_COUNT)))
    else $error("reset request did not start a frame");

  // lines rest with clock high and data low outside a frame
  a_idle_lines: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_item_o.sending |->
      out_item_o.clock_line && !out_item_o.data_line)
    else $error("lines not idle outside a frame");

  a_track_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      out_item_o.track_now <= ams_pkg::TRACK_W'(ams_pkg::TRACK_COUNT))
    else $error("track index out of range");

endmodule

bind audio_module_command_serializer ams_checker u_ams_checker (.*);

[verif/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the audio module command serializer.
// ----------------------------------------------------------------------------
// The stimulus starts with a directed pass over each command but stop and its
// corner cases. Random request streams under several register settings follow.
// A built-in player model predicts the line levels, frame word, volume and
// track after every request. Results are checked in order, field by field.
// ----------------------------------------------------------------------------
module testbench;

  localparam logic [3:0] OP_UNDEF_FIRST = 4'd10;
  localparam logic [3:0] OP_UNDEF_LAST  = 4'd15;

  typedef enum logic [2:0] {
    LINE_IDLE,
    LINE_HOLD,
    LINE_START_LOW,
    LINE_BIT_LOW,
    LINE_BIT_HIGH
  } line_phase_e;

  typedef struct packed {
    logic [ams_pkg::TRACK_W-1:0]    track;
    logic [ams_pkg::VOL_W-1:0]      volume;
    logic [ams_pkg::FRAME_BITS-1:0] shift;
    logic [ams_pkg::BITS_W-1:0]     bits_left;
    line_phase_e                    phase;
    logic [15:0]                    timer;
    logic                           clk_line;
    logic                           data_line;
    logic [ams_pkg::WORD_W-1:0]     word;
  } player_t;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           cfg_we = 1'b0;
  logic [ams_pkg::CFG_IDX_W-1:0]  cfg_idx = '0;
  logic [ams_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                           in_valid = 1'b0;
  logic                           in_stall;
  ams_pkg::in_item_t              in_item = '0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  ams_pkg::out_item_t             out_item;

  ams_pkg::cfg_t      cfg_now;
  player_t            live;     // advanced as the DUT takes requests
  player_t            planned;  // advanced as requests are generated
  ams_pkg::in_item_t  pending_reqs[$];
  ams_pkg::out_item_t expected_q[$];

  bit req_taken = 1'b0;
  bit quiet = 1'b0;
  int gap_left = 0;
  int stall_left = 0;
  int n_requests = 0;
  int n_results = 0;
  int n_taken = 0;
  int n_refused = 0;
  int n_mismatch = 0;
  int n_settings = 0;

  audio_module_command_serializer DUT (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_item_o (out_item)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------- player model

  function automatic player_t fresh_player();
    player_t p;
    p.track     = ams_pkg::TRACK_W'(ams_pkg::TRACK_COUNT);
    p.volume    = ams_pkg::RST_MAX_VOLUME;
    p.shift     = '0;
    p.bits_left = '0;
    p.phase     = LINE_IDLE;
    p.timer     = '0;
    p.clk_line  = 1'b1;
    p.data_line = 1'b0;
    p.word      = '0;
    return p;
  endfunction

  // zero-length timings behave as one tick
  function automatic logic [15:0] at_least_one(input logic [15:0] t);
    return (t == 16'd0) ? 16'd1 : t;
  endfunction

  function automatic void begin_frame(inout player_t p, input ams_pkg::cfg_t c,
                                      input logic [ams_pkg::WORD_W-1:0] w);
    p.word      = w;
    p.shift     = ams_pkg::FRAME_BITS'(w);
    p.bits_left = ams_pkg::BITS_W'(ams_pkg::FRAME_BITS);
    p.phase     = LINE_HOLD;
    p.timer     = at_least_one(c.start_hold_ticks);
    p.clk_line  = 1'b1;
  endfunction

  function automatic void advance_tick(inout player_t p, input ams_pkg::cfg_t c);
    if (p.phase != LINE_IDLE) begin
      if (p.timer != 16'd0) p.timer--;
      if (p.timer == 16'd0) begin
        case (p.phase)
          LINE_HOLD: begin
            p.phase    = LINE_START_LOW;
            p.clk_line = 1'b0;
            p.timer    = at_least_one(c.start_low_ticks);
          end
          LINE_START_LOW, LINE_BIT_HIGH: begin
            if (p.phase == LINE_BIT_HIGH && p.bits_left == '0) begin
              p.phase     = LINE_IDLE;
              p.data_line = 1'b0;
              p.clk_line  = 1'b1;
              p.timer     = '0;
            end else begin
              p.phase     = LINE_BIT_LOW;
              p.clk_line  = 1'b0;
              p.data_line = p.shift[ams_pkg::FRAME_BITS-1];
              p.shift     = p.shift << 1;
              p.bits_left--;
              p.timer     = at_least_one(c.half_bit_ticks);
            end
          end
          default: begin
            p.phase    = LINE_BIT_HIGH;
            p.clk_line = 1'b1;
            p.timer    = at_least_one(c.half_bit_ticks);
          end
        endcase
      end
    end
  endfunction

  function automatic void stop_playback(inout player_t p, input ams_pkg::cfg_t c);
    p.track = ams_pkg::TRACK_W'(ams_pkg::TRACK_COUNT);
    begin_frame(p, c, c.stop_code);
  endfunction

  function automatic void go_to_track(inout player_t p, input ams_pkg::cfg_t c,
                                      input int unsigned idx);
    if (idx < ams_pkg::TRACK_COUNT) begin
      p.track = ams_pkg::TRACK_W'(idx);
      begin_frame(p, c, ams_pkg::WORD_W'(idx));
    end else begin
      stop_playback(p, c);
    end
  endfunction

  // min wins over max when the two are crossed
  function automatic void change_volume(inout player_t p, input ams_pkg::cfg_t c,
                                        input int lv);
    if (lv < int'(c.min_volume)) lv = int'(c.min_volume);
    else if (int'(c.max_volume) < lv) lv = int'(c.max_volume);
    if (lv != int'(p.volume)) begin
      p.volume = ams_pkg::VOL_W'(lv);
      begin_frame(p, c, ams_pkg::WORD_W'(p.volume) + c.volume_base_code);
    end
  endfunction

  function automatic ams_pkg::out_item_t apply_request(inout player_t p,
                                                       input ams_pkg::cfg_t c,
                                                       input ams_pkg::in_item_t it);
    ams_pkg::out_item_t r;
    logic               taken;
    logic               pulse;
    logic               framing;
    taken   = 1'b1;
    pulse   = 1'b0;
    framing = (p.phase != LINE_IDLE);
    if (it.op == ams_pkg::OP_TICK) begin
      advance_tick(p, c);
    end else if (it.op == ams_pkg::OP_RESET) begin
      pulse       = 1'b1;
      p.phase     = LINE_IDLE;
      p.data_line = 1'b0;
      p.track     = ams_pkg::TRACK_W'(ams_pkg::TRACK_COUNT);
      p.volume    = c.max_volume;
      begin_frame(p, c, c.play_pause_code);
    end else if (it.op > ams_pkg::OP_DEC_VOL || framing) begin
      taken = 1'b0;
    end else begin
      case (it.op)
        ams_pkg::OP_PLAY_PAUSE: begin_frame(p, c, it.busy ? c.play_pause_code : '0);
        ams_pkg::OP_PLAY_SONG:  go_to_track(p, c, it.song_index);
        ams_pkg::OP_STOP:       stop_playback(p, c);
        ams_pkg::OP_NEXT:       go_to_track(p, c, it.busy ? int'(p.track) + 1 : 0);
        ams_pkg::OP_PREV: begin
          if (it.busy && p.track == '0) stop_playback(p, c);
          else if (it.busy) go_to_track(p, c, int'(p.track) - 1);
        end
        ams_pkg::OP_SET_VOL:    change_volume(p, c, int'($signed(it.level)));
        ams_pkg::OP_INC_VOL:    change_volume(p, c, int'(p.volume) + 1);
        default:                change_volume(p, c, int'(p.volume) - 1);
      endcase
    end
    r.clock_line  = p.clk_line;
    r.data_line   = p.data_line;
    r.reset_pulse = pulse;
    r.accepted    = taken;
    r.frame_word  = p.word;
    r.sending     = (p.phase != LINE_IDLE);
    r.volume_now  = p.volume;
    r.track_now   = p.track;
    return r;
  endfunction

  // ---------------------------------------------------------------- stimulus

  function automatic void plan_request(input ams_pkg::in_item_t it);
    void'(apply_request(planned, cfg_now, it));
    pending_reqs.push_back(it);
  endfunction

  // ticks until the frame now on the lines is finished
  function automatic void plan_drain();
    ams_pkg::in_item_t it;
    while (planned.phase != LINE_IDLE) begin
      it.op         = ams_pkg::OP_TICK;
      it.song_index = 16'($urandom);
      it.level      = 8'($urandom);
      it.busy       = 1'($urandom);
      plan_request(it);
    end
  endfunction

  function automatic void plan_command(input logic [3:0] op, input logic [15:0] song,
                                       input logic [7:0] lvl, input logic busy,
                                       input bit finish);
    ams_pkg::in_item_t it;
    it.op         = op;
    it.song_index = song;
    it.level      = lvl;
    it.busy       = busy;
    plan_request(it);
    if (finish) plan_drain();
  endfunction

  // idle lines get mostly commands; a running frame gets mostly ticks
  function automatic ams_pkg::in_item_t random_request();
    ams_pkg::in_item_t it;
    int unsigned       pick;
    pick          = $urandom_range(0, 39);
    it.song_index = ($urandom_range(0, 7) == 0) ? 16'($urandom)
                                                : 16'($urandom_range(0, 600));
    it.level      = ($urandom_range(0, 3) == 0) ? 8'($urandom)
                                                : 8'($urandom_range(0, 19) - 2);
    it.busy       = 1'($urandom);
    if (planned.phase == LINE_IDLE) begin
      if (pick < 2) it.op = 4'($urandom_range(OP_UNDEF_FIRST, OP_UNDEF_LAST));
      else if (pick < 5) it.op = ams_pkg::OP_TICK;
      else if (pick < 7) it.op = ams_pkg::OP_RESET;
      else it.op = 4'($urandom_range(ams_pkg::OP_PLAY_PAUSE, ams_pkg::OP_DEC_VOL));
    end else begin
      if (pick < 3) it.op = 4'($urandom_range(ams_pkg::OP_PLAY_PAUSE, ams_pkg::OP_DEC_VOL));
      else if (pick == 3) it.op = 4'($urandom_range(OP_UNDEF_FIRST, OP_UNDEF_LAST));
      else if (pick == 4 && $urandom_range(0, 3) == 0) it.op = ams_pkg::OP_RESET;
      else it.op = ams_pkg::OP_TICK;
    end
    return it;
  endfunction

  task automatic write_reg(input ams_pkg::cfg_idx_e idx,
                           input logic [ams_pkg::CFG_DATA_W-1:0] v);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= v;
    case (idx)
      ams_pkg::CFG_PLAY_PAUSE_CODE:  cfg_now.play_pause_code  = v;
      ams_pkg::CFG_STOP_CODE:        cfg_now.stop_code        = v;
      ams_pkg::CFG_VOLUME_BASE_CODE: cfg_now.volume_base_code = v;
      ams_pkg::CFG_MIN_VOLUME:       cfg_now.min_volume       = v[ams_pkg::VOL_W-1:0];
      ams_pkg::CFG_MAX_VOLUME:       cfg_now.max_volume       = v[ams_pkg::VOL_W-1:0];
      ams_pkg::CFG_START_HOLD_TICKS: cfg_now.start_hold_ticks = v;
      ams_pkg::CFG_START_LOW_TICKS:  cfg_now.start_low_ticks  = v;
      default:                       cfg_now.half_bit_ticks   = v;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic settle();
    while (pending_reqs.size() != 0 || in_valid || expected_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_codes(input logic [15:0] pp, input logic [15:0] stp,
                             input logic [15:0] base);
    write_reg(ams_pkg::CFG_PLAY_PAUSE_CODE, pp);
    write_reg(ams_pkg::CFG_STOP_CODE, stp);
    write_reg(ams_pkg::CFG_VOLUME_BASE_CODE, base);
  endtask

  task automatic write_limits(input logic [15:0] lo, input logic [15:0] hi);
    write_reg(ams_pkg::CFG_MIN_VOLUME, lo);
    write_reg(ams_pkg::CFG_MAX_VOLUME, hi);
  endtask

  task automatic write_timing(input logic [15:0] hold, input logic [15:0] low,
                              input logic [15:0] half);
    write_reg(ams_pkg::CFG_START_HOLD_TICKS, hold);
    write_reg(ams_pkg::CFG_START_LOW_TICKS, low);
    write_reg(ams_pkg::CFG_HALF_BIT_TICKS, half);
    n_settings++;
  endtask

  initial begin
    cfg_now = '{ams_pkg::RST_PLAY_PAUSE, ams_pkg::RST_STOP, ams_pkg::RST_VOLUME_BASE,
                ams_pkg::RST_MIN_VOLUME, ams_pkg::RST_MAX_VOLUME, ams_pkg::RST_HOLD_TICKS,
                ams_pkg::RST_LOW_TICKS, ams_pkg::RST_HALF_TICKS};
    live    = fresh_player();
    planned = fresh_player();
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    // directed pass over every command but stop
    write_codes(16'hA5C3, 16'h5A3C, 16'hFFF0);
    write_limits(16'd1, 16'd7);
    write_timing(16'd1, 16'd1, 16'd1);
    plan_command(ams_pkg::OP_TICK, 16'hFFFF, 8'h80, 1'b1, 1'b0);       // idle tick
    plan_command(ams_pkg::OP_PLAY_PAUSE, 16'h0000, 8'h00, 1'b1, 1'b1);
    plan_command(ams_pkg::OP_PLAY_PAUSE, 16'h0000, 8'h00, 1'b0, 1'b1); // word zero
    plan_command(ams_pkg::OP_PLAY_SONG, 16'd511, 8'h00, 1'b0, 1'b1);
    plan_command(ams_pkg::OP_NEXT, 16'h0000, 8'h00, 1'b1, 1'b1);       // past last
    plan_command(ams_pkg::OP_PREV, 16'h0000, 8'h00, 1'b1, 1'b1);       // from stopped
    plan_command(ams_pkg::OP_NEXT, 16'h0000, 8'h00, 1'b0, 1'b1);       // to track 0
    plan_command(ams_pkg::OP_PREV, 16'h0000, 8'h00, 1'b1, 1'b1);       // below 0
    plan_command(ams_pkg::OP_PREV, 16'h0000, 8'h00, 1'b0, 1'b1);       // nothing
    plan_command(ams_pkg::OP_SET_VOL, 16'h0000, 8'h80, 1'b0, 1'b1);
    plan_command(ams_pkg::OP_SET_VOL, 16'h0000, 8'h7F, 1'b0, 1'b1);
    plan_command(ams_pkg::OP_SET_VOL, 16'h0000, 8'h7F, 1'b0, 1'b1);    // unchanged
    plan_command(ams_pkg::OP_INC_VOL, 16'h0000, 8'h00, 1'b0, 1'b1);    // at max
    plan_command(ams_pkg::OP_RESET, 16'h0000, 8'h00, 1'b0, 1'b0);
    plan_command(ams_pkg::OP_PLAY_SONG, 16'd5, 8'h00, 1'b1, 1'b0);     // mid-frame
    plan_command(OP_UNDEF_LAST, 16'h0000, 8'h00, 1'b0, 1'b0);
    plan_command(ams_pkg::OP_RESET, 16'h0000, 8'h00, 1'b0, 1'b1);      // aborts frame
    plan_command(OP_UNDEF_FIRST, 16'h0000, 8'h00, 1'b0, 1'b1);
    plan_command(ams_pkg::OP_DEC_VOL, 16'h0000, 8'h00, 1'b0, 1'b0);
    settle();

    // shortest timing, random codes, full volume span
    write_codes(16'($urandom), 16'($urandom), 16'($urandom));
    write_limits({12'($urandom), 4'h0}, {12'($urandom), 4'hF});
    write_timing(16'd0, 16'd0, 16'd0);
    repeat (40) plan_request(random_request());
    plan_drain();
    settle();

    // extreme codes, crossed volume limits
    write_codes(16'h0000, 16'hFFFF, 16'hFFFF);
    write_limits(16'd15, 16'd0);
    write_timing(16'($urandom_range(1, 3)), 16'($urandom_range(1, 3)),
                 16'($urandom_range(1, 3)));
    repeat (40) plan_request(random_request());
    plan_drain();
    settle();

    write_codes(16'($urandom), 16'($urandom), 16'($urandom));
    write_limits(16'($urandom), 16'($urandom));
    write_timing(16'($urandom_range(0, 4)), 16'($urandom_range(0, 4)),
                 16'($urandom_range(0, 4)));
    repeat (40) plan_request(random_request());
    plan_drain();
    settle();

    // longest timing: frames never finish, so commands get refused
    quiet = 1'b1;
    write_codes(16'hFFFF, 16'h0000, 16'h0000);
    write_limits(16'd0, 16'd15);
    write_timing(16'hFFFF, 16'hFFFF, 16'hFFFF);
    repeat (30) plan_request(random_request());
    settle();
    repeat (20) @(negedge clk);

    $display("Checked %0d results for %0d requests under %0d register settings",
             n_results, n_requests, n_settings);
    $display("Commands taken: %0d, refused or ignored: %0d, mismatches: %0d",
             n_taken, n_refused, n_mismatch);
    if (n_mismatch == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Timed out with %0d results outstanding", expected_q.size());
    $display("Some tests failed");
    $finish;
  end

  // ---------------------------------------------------------------- driver

  always @(negedge clk) begin
    if (rst_n && (!in_valid || req_taken)) begin
      if (req_taken && !quiet && $urandom_range(0, 5) == 0) gap_left = $urandom_range(1, 14);
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending_reqs.size() != 0) begin
        in_item  <= pending_reqs.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
      if (!quiet && $urandom_range(0, 9) == 0) stall_left = $urandom_range(1, 14);
    end
  end

  // ---------------------------------------------------------------- monitor

  function automatic string describe(input ams_pkg::out_item_t r);
    return $sformatf("clk=%b dat=%b rst=%b acc=%b word=%h send=%b vol=%0d trk=%0d",
                     r.clock_line, r.data_line, r.reset_pulse, r.accepted, r.frame_word,
                     r.sending, r.volume_now, r.track_now);
  endfunction

  always @(posedge clk) begin : check_results
    ams_pkg::out_item_t want;
    logic               bad;
    req_taken = rst_n && in_valid && !in_stall;
    if (req_taken) begin
      want = apply_request(live, cfg_now, in_item);
      expected_q.push_back(want);
      n_requests++;
      if (in_item.op != ams_pkg::OP_TICK) begin
        if (want.accepted) n_taken++;
        else n_refused++;
      end
    end
    if (rst_n && out_valid && !out_stall) begin
      n_results++;
      if (expected_q.size() == 0) begin
        if (n_mismatch < 10) $display("Unexpected result %s", describe(out_item));
        n_mismatch++;
      end else begin
        want = expected_q.pop_front();
        bad  = out_item.clock_line !== want.clock_line
            || out_item.data_line !== want.data_line
            || out_item.reset_pulse !== want.reset_pulse
            || out_item.accepted !== want.accepted
            || out_item.frame_word !== want.frame_word
            || out_item.sending !== want.sending
            || out_item.volume_now !== want.volume_now
            || out_item.track_now !== want.track_now;
        if (bad) begin
          if (n_mismatch < 10) begin
            $display("Mismatch on result %0d at %0t", n_results, $realtime);
            $display("  expected %s", describe(want));
            $display("  actual   %s", describe(out_item));
          end
          n_mismatch++;
        end
      end
    end
  end

endmodule

[files.f]
hw/rtl/ams_pkg.sv
hw/rtl/ams_cfg.sv
hw/rtl/ams_ctrl.sv
hw/rtl/ams_frame.sv
hw/rtl/audio_module_command_serializer.sv
hw/rtl/ams_checker.sv
verif/testbench.sv
